FILE: rtl/pmd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the distance core.
package pmd_pkg;

   // Store dimensions.
   localparam int MAX_POINTS = 64;
   localparam int MAX_DIMS   = 16;

   // Field widths.
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 6;
   localparam int VALUE_W  = 16;
   localparam int NDIMS_W  = 5;
   localparam int DIST_W   = 64;

   // Derived widths.
   localparam int DIM_W      = $clog2(MAX_DIMS);
   localparam int PT_W       = $clog2(MAX_POINTS);
   localparam int DCNT_W     = $clog2(MAX_DIMS + 1);
   localparam int PT_ADDR_W  = PT_W + DIM_W;
   localparam int WT_ADDR_W  = 2 * DIM_W;
   localparam int PT_DEPTH   = MAX_POINTS * MAX_DIMS;
   localparam int WT_DEPTH   = MAX_DIMS * MAX_DIMS;
   localparam int DIFF_W     = VALUE_W + 1;
   localparam int PROD1_W    = DIFF_W + VALUE_W;
   localparam int PROD2_W    = PROD1_W + DIFF_W;

   // Stream payload layout.
   localparam int FI_LSB      = 0;
   localparam int SI_LSB      = FI_LSB + INDEX_W;
   localparam int VAL_LSB     = SI_LSB + INDEX_W;
   localparam int REQ_BITS    = VAL_LSB + VALUE_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = DIST_W + 2 * INDEX_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [NDIMS_W-1:0] NUM_DIMS_RESET = NDIMS_W'(16);

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_POINT  = 2'd0,
      OP_WRITE_WEIGHT = 2'd1,
      OP_COMPUTE      = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SETTLE,
      ST_ROW_LOAD,
      ST_ROW_CAPTURE,
      ST_MAC,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             capture_req;
      logic             pt_wr;
      logic             wt_wr;
      logic             pt_rd;
      logic             pt_second;
      logic [DIM_W-1:0] coord;
      logic             row_rd;
      logic             row_capture;
      logic             mac_rd;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic             load_result;
   } dp_cmd_type;

   typedef struct packed {
      logic pt_idx_ok;
      logic wt_idx_ok;
      logic pair_ok;
      logic pipe_busy;
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/pmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pmd_datapath.sv
// Datapath: point, weight and difference stores, the shared multiply-accumulate and the result register.
module pmd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pmd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  pmd_pkg::dp_cmd_type               cmd,
   output pmd_pkg::dp_status_type            status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pmd_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [pmd_pkg::INDEX_W-1:0] req_fi;
   logic [pmd_pkg::INDEX_W-1:0] req_si;
   logic [pmd_pkg::VALUE_W-1:0] req_value;

   assign req_fi    = req_tdata[pmd_pkg::FI_LSB +: pmd_pkg::INDEX_W];
   assign req_si    = req_tdata[pmd_pkg::SI_LSB +: pmd_pkg::INDEX_W];
   assign req_value = req_tdata[pmd_pkg::VAL_LSB +: pmd_pkg::VALUE_W];

   // Captured pair of the compute item in progress.
   logic [pmd_pkg::INDEX_W-1:0] fi_ff, si_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         fi_ff <= req_fi;
         si_ff <= req_si;
      end
   end

   // Point store.
   logic                          pt_wr_en;
   logic [pmd_pkg::PT_ADDR_W-1:0] pt_wr_addr, pt_rd_addr;
   logic [pmd_pkg::INDEX_W-1:0]   pt_rd_point;
   logic [pmd_pkg::VALUE_W-1:0]   pt_rd_data;

   assign pt_wr_en    = cmd.pt_wr;
   assign pt_wr_addr  = {req_fi[pmd_pkg::PT_W-1:0], req_si[pmd_pkg::DIM_W-1:0]};
   assign pt_rd_point = cmd.pt_second ? si_ff : fi_ff;
   assign pt_rd_addr  = {pt_rd_point[pmd_pkg::PT_W-1:0], cmd.coord};

   pmd_ram #(
      .WIDTH(pmd_pkg::VALUE_W),
      .DEPTH(pmd_pkg::PT_DEPTH)
   ) u_point_ram (
      .clock  (clock),
      .wr_en  (pt_wr_en),
      .wr_addr(pt_wr_addr),
      .wr_data(req_value),
      .rd_en  (cmd.pt_rd),
      .rd_addr(pt_rd_addr),
      .rd_data(pt_rd_data)
   );

   // Weight store.
   logic [pmd_pkg::WT_ADDR_W-1:0] wt_wr_addr, wt_rd_addr;
   logic [pmd_pkg::VALUE_W-1:0]   wt_rd_data;

   assign wt_wr_addr = {req_fi[pmd_pkg::DIM_W-1:0], req_si[pmd_pkg::DIM_W-1:0]};
   assign wt_rd_addr = {cmd.row, cmd.col};

   pmd_ram #(
      .WIDTH(pmd_pkg::VALUE_W),
      .DEPTH(pmd_pkg::WT_DEPTH)
   ) u_weight_ram (
      .clock  (clock),
      .wr_en  (cmd.wt_wr),
      .wr_addr(wt_wr_addr),
      .wr_data(req_value),
      .rd_en  (cmd.mac_rd),
      .rd_addr(wt_rd_addr),
      .rd_data(wt_rd_data)
   );

   // Difference pass: first coordinate is held, second arrives in the following cycle.
   logic                          pt_v_ff, pt_second_ff;
   logic [pmd_pkg::DIM_W-1:0]     pt_coord_ff;
   logic [pmd_pkg::VALUE_W-1:0]   first_ff;
   logic                          diff_wr_en;
   logic signed [pmd_pkg::DIFF_W-1:0] diff_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_v_ff <= 1'b0;
      end else begin
         pt_v_ff <= cmd.pt_rd;
      end
   end

   always_ff @(posedge clock) begin
      pt_second_ff <= cmd.pt_second;
      pt_coord_ff  <= cmd.coord;
      if (pt_v_ff && !pt_second_ff) begin
         first_ff <= pt_rd_data;
      end
   end

   assign diff_wr_en   = pt_v_ff && pt_second_ff;
   assign diff_wr_data = pmd_pkg::DIFF_W'($signed(first_ff))
                       - pmd_pkg::DIFF_W'($signed(pt_rd_data));

   // Difference store, read either for the row operand or for the column operand.
   logic                                diff_rd_en;
   logic [pmd_pkg::DIM_W-1:0]           diff_rd_addr;
   logic signed [pmd_pkg::DIFF_W-1:0]   diff_rd_data;

   assign diff_rd_en   = cmd.row_rd || cmd.mac_rd;
   assign diff_rd_addr = cmd.row_rd ? cmd.row : cmd.col;

   pmd_ram #(
      .WIDTH(pmd_pkg::DIFF_W),
      .DEPTH(pmd_pkg::MAX_DIMS)
   ) u_diff_ram (
      .clock  (clock),
      .wr_en  (diff_wr_en),
      .wr_addr(pt_coord_ff),
      .wr_data(diff_wr_data),
      .rd_en  (diff_rd_en),
      .rd_addr(diff_rd_addr),
      .rd_data(diff_rd_data)
   );

   // Multiply-accumulate pipeline: d[a]*B[a][b], then times d[b], then accumulate.
   logic signed [pmd_pkg::DIFF_W-1:0]  da_ff, db_ff;
   logic signed [pmd_pkg::PROD1_W-1:0] p1_ff, p1_in;
   logic signed [pmd_pkg::PROD2_W-1:0] p2_ff, p2_in;
   logic signed [pmd_pkg::DIST_W-1:0]  acc_ff, acc_in;
   logic                               mac_v_ff, p1_v_ff, p2_v_ff;

   assign p1_in  = pmd_pkg::PROD1_W'(da_ff) * pmd_pkg::PROD1_W'($signed(wt_rd_data));
   assign p2_in  = pmd_pkg::PROD2_W'(p1_ff) * pmd_pkg::PROD2_W'(db_ff);
   assign acc_in = acc_ff + pmd_pkg::DIST_W'(p2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v_ff <= 1'b0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
      end else begin
         mac_v_ff <= cmd.mac_rd;
         p1_v_ff  <= mac_v_ff;
         p2_v_ff  <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_capture) begin
         da_ff <= diff_rd_data;
      end
      if (mac_v_ff) begin
         p1_ff <= p1_in;
         db_ff <= diff_rd_data;
      end
      if (p1_v_ff) begin
         p2_ff <= p2_in;
      end
      if (cmd.capture_req) begin
         acc_ff <= '0;
      end else if (p2_v_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Result register.
   logic                            rsp_valid_ff;
   logic [pmd_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_data_ff <= pmd_pkg::RSP_TDATA_W'({si_ff, fi_ff, acc_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status towards the controller.
   assign status.pt_idx_ok = ({1'b0, req_fi} < (pmd_pkg::INDEX_W + 1)'(pmd_pkg::MAX_POINTS))
                          && ({1'b0, req_si} < (pmd_pkg::INDEX_W + 1)'(pmd_pkg::MAX_DIMS));
   assign status.wt_idx_ok = ({1'b0, req_fi} < (pmd_pkg::INDEX_W + 1)'(pmd_pkg::MAX_DIMS))
                          && ({1'b0, req_si} < (pmd_pkg::INDEX_W + 1)'(pmd_pkg::MAX_DIMS));
   assign status.pair_ok   = (req_fi < req_si)
                          && ({1'b0, req_si} < (pmd_pkg::INDEX_W + 1)'(pmd_pkg::MAX_POINTS));
   assign status.pipe_busy = mac_v_ff || p1_v_ff || p2_v_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

FILE: rtl/pmd_controller.sv
// Controller: sequences writes, the difference pass, the row/column product loops and the result hand-off.
module pmd_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [pmd_pkg::NDIMS_W-1:0]    csr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pmd_pkg::OPCODE_W-1:0]   req_opcode,
   input  pmd_pkg::dp_status_type         status,
   output pmd_pkg::dp_cmd_type            cmd,
   output pmd_pkg::state_type             state
);

   pmd_pkg::state_type state_ff, state_in;

   logic [pmd_pkg::NDIMS_W-1:0] num_dims_ff;
   logic [pmd_pkg::DCNT_W:0]    step_ff, step_in;
   logic [pmd_pkg::DIM_W-1:0]   row_ff, row_in;
   logic [pmd_pkg::DIM_W-1:0]   col_ff, col_in;

   logic [pmd_pkg::DCNT_W-1:0]  dims;
   logic [pmd_pkg::DCNT_W:0]    diff_last;
   logic [pmd_pkg::DCNT_W-1:0]  dims_m1;
   logic [pmd_pkg::DIM_W-1:0]   dims_last;

   // Dimension count in use, saturated to the store size.
   assign dims = ({1'b0, num_dims_ff} > (pmd_pkg::NDIMS_W + 1)'(pmd_pkg::MAX_DIMS))
               ? pmd_pkg::DCNT_W'(pmd_pkg::MAX_DIMS)
               : pmd_pkg::DCNT_W'(num_dims_ff);
   assign diff_last = {dims, 1'b0} - (pmd_pkg::DCNT_W + 1)'(1);
   assign dims_m1   = dims - pmd_pkg::DCNT_W'(1);
   assign dims_last = dims_m1[pmd_pkg::DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= pmd_pkg::NUM_DIMS_RESET;
      end else if (csr_valid) begin
         num_dims_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmd_pkg::ST_IDLE;
         step_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pmd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_opcode)
                  pmd_pkg::OP_WRITE_POINT: begin
                     cmd.pt_wr = status.pt_idx_ok;
                  end
                  pmd_pkg::OP_WRITE_WEIGHT: begin
                     cmd.wt_wr = status.wt_idx_ok;
                  end
                  pmd_pkg::OP_COMPUTE: begin
                     cmd.capture_req = 1'b1;
                     step_in = '0;
                     row_in  = '0;
                     col_in  = '0;
                     if (status.pair_ok && (dims != '0)) begin
                        state_in = pmd_pkg::ST_DIFF;
                     end else begin
                        state_in = pmd_pkg::ST_RESULT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pmd_pkg::ST_DIFF: begin
            cmd.pt_rd     = 1'b1;
            cmd.pt_second = step_ff[0];
            cmd.coord     = step_ff[pmd_pkg::DIM_W:1];
            if (step_ff == diff_last) begin
               state_in = pmd_pkg::ST_SETTLE;
            end else begin
               step_in = step_ff + (pmd_pkg::DCNT_W + 1)'(1);
            end
         end
         pmd_pkg::ST_SETTLE: begin
            state_in = pmd_pkg::ST_ROW_LOAD;
         end
         pmd_pkg::ST_ROW_LOAD: begin
            cmd.row_rd = 1'b1;
            cmd.row    = row_ff;
            state_in   = pmd_pkg::ST_ROW_CAPTURE;
         end
         pmd_pkg::ST_ROW_CAPTURE: begin
            cmd.row_capture = 1'b1;
            col_in          = '0;
            state_in        = pmd_pkg::ST_MAC;
         end
         pmd_pkg::ST_MAC: begin
            cmd.mac_rd = 1'b1;
            cmd.row    = row_ff;
            cmd.col    = col_ff;
            if (col_ff == dims_last) begin
               if (row_ff == dims_last) begin
                  state_in = pmd_pkg::ST_DRAIN;
               end else begin
                  row_in   = row_ff + pmd_pkg::DIM_W'(1);
                  state_in = pmd_pkg::ST_ROW_LOAD;
               end
            end else begin
               col_in = col_ff + pmd_pkg::DIM_W'(1);
            end
         end
         pmd_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = pmd_pkg::ST_RESULT;
            end
         end
         pmd_pkg::ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = pmd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmd_pkg::ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

FILE: rtl/pairwise_mahalanobis_distance_core.sv
// Top level of the squared Mahalanobis distance core.
//
// This core stores up to 64 points of 16 signed Q8.8 coordinates and a 16 x 16 signed Q8.8
// weight matrix B, and answers compute requests with the exact quadratic form d^T B d, where
// d is the difference of two stored points over the first D coordinates (D is the dimension
// register, saturated to 16). The result is a signed 64-bit value with 24 fraction bits, and
// it is 0 when the first index is not below the second, when the second index is outside the
// point store or when D is 0. Write requests (point coordinate or weight entry) produce no
// response; writes outside the stores and the unused opcode are accepted and dropped. A
// compute request keeps the core busy until its response is loaded into the output register.
// Its work is done by the single shared multiply-accumulate, which visits every weight entry
// of the first D rows and columns once and fetches the row operand before each matrix row,
// after the differences are formed through the single read port of the point store. A pair
// that needs no work goes straight to the result. Stores are not cleared at reset: reading
// an entry that was never written gives an undefined result.
module pairwise_mahalanobis_distance_core (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration: number of dimensions in use.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmd_pkg::NDIMS_W-1:0]       csr_data,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata, lowest bit up: first_index[5:0], second_index[11:6], value[27:12], zero[31:28].
   input  logic [pmd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: opcode[1:0].
   input  logic [pmd_pkg::OPCODE_W-1:0]      req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata, lowest bit up: distance[63:0], pair_first[69:64], pair_second[75:70], zero[79:76].
   output logic [pmd_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   pmd_pkg::dp_cmd_type    cmd;
   pmd_pkg::dp_status_type status;
   pmd_pkg::state_type     state;

   // The dimension register may take a transfer in any cycle.
   assign csr_ready = 1'b1;

   pmd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_opcode(req_tuser),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   pmd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Requests are only taken while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state != pmd_pkg::ST_IDLE) |-> !req_tready)
      else $error("request ready outside idle");

   // A write or unused opcode never raises a response.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != pmd_pkg::OP_COMPUTE) && !rsp_tvalid)
      |=> !rsp_tvalid)
      else $error("response raised by a non-compute request");

   // At most one of the point read, the row read and the product read is issued per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pt_rd, cmd.row_rd, cmd.mac_rd}))
      else $error("conflicting store reads");

   // A finished result reaches the output register as soon as it is free.
   assert property (@(posedge clock) disable iff (reset)
      ((state == pmd_pkg::ST_RESULT) && status.rsp_free) |=> rsp_tvalid)
      else $error("finished result not presented");

endmodule
